### design/stla_pkg.sv
// Package for the segment table: codes, types and controller/datapath interface structs.
package stla_pkg;

    localparam int ENTRIES  = 32;
    localparam int AGE_BITS = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int OP_W     = 3;
    localparam int KEY_W    = 8;
    localparam int ST_W     = 2;
    localparam int SLOT_W   = 5;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_TOUCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_VICTIM = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]    pid;
        logic [KEY_W-1:0]    seg;
        logic [AGE_BITS-1:0] age;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INSERT,
        S_FIND,
        S_AGE,
        S_SHIFT,
        S_VICTIM,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        SM_FIND,
        SM_AGE,
        SM_SHIFT,
        SM_MAX
    } scan_mode_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_NOT_FOUND,
        RES_FULL,
        RES_EMPTY,
        RES_HIT,
        RES_BEST
    } res_t;

    typedef struct packed {
        logic       accept;
        logic       scan_start;
        logic       scan_from_pos;
        logic       scan_en;
        scan_mode_t mode;
        logic       insert;
        logic       dec_count;
        logic       res_load;
        res_t       res_sel;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            hit;
        logic            scan_done;
        logic            out_free;
    } sts_t;

endpackage

### design/stla_dp.sv
// Datapath: entry memory, count, scan pipeline, match/victim trackers and result registers.
module stla_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stla_pkg::cmd_t               cmd,
    output stla_pkg::sts_t               sts,
    input  logic [stla_pkg::OP_W-1:0]    opcode,
    input  logic [stla_pkg::KEY_W-1:0]   process_id,
    input  logic [stla_pkg::KEY_W-1:0]   seg_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [stla_pkg::ST_W-1:0]    status,
    output logic [stla_pkg::KEY_W-1:0]   found_pid,
    output logic [stla_pkg::KEY_W-1:0]   found_seg,
    output logic [stla_pkg::SLOT_W-1:0]  found_slot
);

    stla_pkg::entry_t mem [stla_pkg::ENTRIES];

    logic [stla_pkg::OP_W-1:0]     op_reg;
    logic [stla_pkg::KEY_W-1:0]    kpid_reg;
    logic [stla_pkg::KEY_W-1:0]    kseg_reg;
    logic [stla_pkg::CNT_W-1:0]    count_reg;
    logic [stla_pkg::CNT_W-1:0]    count_next;
    logic [stla_pkg::CNT_W-1:0]    idx_reg;
    logic [stla_pkg::CNT_W-1:0]    idx_next;
    logic                          pv_reg;
    logic                          pv_next;
    logic [stla_pkg::IDX_W-1:0]    pidx_reg;
    stla_pkg::entry_t              rdata_reg;

    logic [stla_pkg::IDX_W-1:0]    hpos_reg;
    logic [stla_pkg::KEY_W-1:0]    hpid_reg;
    logic [stla_pkg::KEY_W-1:0]    hseg_reg;
    logic [stla_pkg::IDX_W-1:0]    bpos_reg;
    logic [stla_pkg::KEY_W-1:0]    bpid_reg;
    logic [stla_pkg::KEY_W-1:0]    bseg_reg;
    logic [stla_pkg::AGE_BITS-1:0] bage_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [stla_pkg::ST_W-1:0]     status_reg;
    logic [stla_pkg::KEY_W-1:0]    fpid_reg;
    logic [stla_pkg::KEY_W-1:0]    fseg_reg;
    logic [stla_pkg::SLOT_W-1:0]   fslot_reg;

    logic                          rd_en;
    logic                          hit;
    logic                          wr_en;
    logic [stla_pkg::IDX_W-1:0]    wr_addr;
    stla_pkg::entry_t              wr_data;
    logic [stla_pkg::AGE_BITS-1:0] aged;

    assign rd_en = cmd.scan_en && !cmd.scan_start && (idx_reg < count_reg);
    assign hit   = pv_reg && (rdata_reg.pid == kpid_reg) && (rdata_reg.seg == kseg_reg);
    assign aged  = (rdata_reg.age == '1) ? rdata_reg.age : rdata_reg.age + 1'b1;

    assign sts.op        = op_reg;
    assign sts.full      = (count_reg == stla_pkg::CNT_W'(stla_pkg::ENTRIES));
    assign sts.empty     = (count_reg == '0);
    assign sts.hit       = hit;
    assign sts.scan_done = !pv_reg && !(idx_reg < count_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // write port: insert at tail, age in place, or shift down by one
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pidx_reg;
        wr_data = rdata_reg;
        if (cmd.insert)
        begin
            wr_en       = 1'b1;
            wr_addr     = count_reg[stla_pkg::IDX_W-1:0];
            wr_data.pid = kpid_reg;
            wr_data.seg = kseg_reg;
            wr_data.age = '0;
        end
        else if (cmd.scan_en && pv_reg && cmd.mode == stla_pkg::SM_AGE)
        begin
            wr_en       = 1'b1;
            wr_data.age = (pidx_reg == hpos_reg) ? '0 : aged;
        end
        else if (cmd.scan_en && pv_reg && cmd.mode == stla_pkg::SM_SHIFT)
        begin
            wr_en   = 1'b1;
            wr_addr = pidx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[idx_reg[stla_pkg::IDX_W-1:0]];
            pidx_reg  <= idx_reg[stla_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        pv_next  = 1'b0;
        if (cmd.scan_start)
        begin
            idx_next = cmd.scan_from_pos ? {1'b0, pidx_reg} + 1'b1 : '0;
        end
        else if (rd_en)
        begin
            idx_next = idx_reg + 1'b1;
            pv_next  = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign out_valid_next = cmd.res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            kpid_reg <= process_id;
            kseg_reg <= seg_number;
        end
        if (cmd.insert)
        begin
            hpos_reg <= count_reg[stla_pkg::IDX_W-1:0];
            hpid_reg <= kpid_reg;
            hseg_reg <= kseg_reg;
        end
        else if (cmd.scan_en && cmd.mode == stla_pkg::SM_FIND && hit)
        begin
            hpos_reg <= pidx_reg;
            hpid_reg <= rdata_reg.pid;
            hseg_reg <= rdata_reg.seg;
        end
        // strict compare keeps the earliest entry on a tie
        if (cmd.scan_en && cmd.mode == stla_pkg::SM_MAX && pv_reg
            && (pidx_reg == '0 || rdata_reg.age > bage_reg))
        begin
            bpos_reg <= pidx_reg;
            bpid_reg <= rdata_reg.pid;
            bseg_reg <= rdata_reg.seg;
            bage_reg <= rdata_reg.age;
        end
        if (cmd.res_load)
        begin
            fpid_reg  <= '0;
            fseg_reg  <= '0;
            fslot_reg <= '0;
            case (cmd.res_sel)
                stla_pkg::RES_NOT_FOUND: status_reg <= stla_pkg::ST_NOT_FOUND;
                stla_pkg::RES_FULL:      status_reg <= stla_pkg::ST_FULL;
                stla_pkg::RES_EMPTY:     status_reg <= stla_pkg::ST_EMPTY;
                stla_pkg::RES_HIT:
                begin
                    status_reg <= stla_pkg::ST_OK;
                    fpid_reg   <= hpid_reg;
                    fseg_reg   <= hseg_reg;
                    fslot_reg  <= stla_pkg::SLOT_W'(hpos_reg);
                end
                stla_pkg::RES_BEST:
                begin
                    status_reg <= stla_pkg::ST_OK;
                    fpid_reg   <= bpid_reg;
                    fseg_reg   <= bseg_reg;
                    fslot_reg  <= stla_pkg::SLOT_W'(bpos_reg);
                end
                default:                 status_reg <= stla_pkg::ST_OK;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_pid  = fpid_reg;
    assign found_seg  = fseg_reg;
    assign found_slot = fslot_reg;

endmodule

### design/stla_ctrl.sv
// Controller: sequences scans of the entry memory for the opcodes that need them.
module stla_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  stla_pkg::sts_t  sts,
    output stla_pkg::cmd_t  cmd
);

    stla_pkg::state_t state_reg;
    stla_pkg::state_t state_next;
    stla_pkg::res_t   res_reg;
    stla_pkg::res_t   res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stla_pkg::S_IDLE;
            res_reg   <= stla_pkg::RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        res_next          = res_reg;
        in_ready          = 1'b0;
        cmd               = '0;
        cmd.mode          = stla_pkg::SM_FIND;
        cmd.res_sel       = res_reg;
        unique case (state_reg)
            stla_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = stla_pkg::S_DISPATCH;
                end
            end
            stla_pkg::S_DISPATCH:
            begin
                case (sts.op) inside
                    stla_pkg::OP_LOOKUP, stla_pkg::OP_TOUCH, stla_pkg::OP_REMOVE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = stla_pkg::S_FIND;
                    end
                    stla_pkg::OP_INSERT:
                    begin
                        state_next = stla_pkg::S_INSERT;
                    end
                    stla_pkg::OP_VICTIM:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = stla_pkg::S_VICTIM;
                    end
                    default:
                    begin
                        res_next   = stla_pkg::RES_NONE;
                        state_next = stla_pkg::S_RESP;
                    end
                endcase
            end
            stla_pkg::S_INSERT:
            begin
                cmd.insert = !sts.full;
                res_next   = sts.full ? stla_pkg::RES_FULL : stla_pkg::RES_HIT;
                state_next = stla_pkg::S_RESP;
            end
            stla_pkg::S_FIND:
            begin
                cmd.scan_en = 1'b1;
                cmd.mode    = stla_pkg::SM_FIND;
                if (sts.hit)
                begin
                    res_next = stla_pkg::RES_HIT;
                    case (sts.op)
                        stla_pkg::OP_TOUCH:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = stla_pkg::S_AGE;
                        end
                        stla_pkg::OP_REMOVE:
                        begin
                            // restart just past the hit to pull later entries down
                            cmd.scan_start    = 1'b1;
                            cmd.scan_from_pos = 1'b1;
                            state_next        = stla_pkg::S_SHIFT;
                        end
                        default:
                        begin
                            state_next = stla_pkg::S_RESP;
                        end
                    endcase
                end
                else if (sts.scan_done)
                begin
                    res_next   = stla_pkg::RES_NOT_FOUND;
                    state_next = stla_pkg::S_RESP;
                end
            end
            stla_pkg::S_AGE:
            begin
                cmd.scan_en = 1'b1;
                cmd.mode    = stla_pkg::SM_AGE;
                if (sts.scan_done)
                begin
                    state_next = stla_pkg::S_RESP;
                end
            end
            stla_pkg::S_SHIFT:
            begin
                cmd.scan_en = 1'b1;
                cmd.mode    = stla_pkg::SM_SHIFT;
                if (sts.scan_done)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = stla_pkg::S_RESP;
                end
            end
            stla_pkg::S_VICTIM:
            begin
                cmd.scan_en = 1'b1;
                cmd.mode    = stla_pkg::SM_MAX;
                if (sts.scan_done)
                begin
                    res_next   = sts.empty ? stla_pkg::RES_EMPTY : stla_pkg::RES_BEST;
                    state_next = stla_pkg::S_RESP;
                end
            end
            stla_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = stla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/segment_table_lru_aging.sv
// Top level of the segment table with LRU aging: controller plus datapath.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   opcode, process_id, seg_number
//   out      out  out_valid/out_ready status, found_pid, found_seg, found_slot
//
// One beat at a time; n resident entries, one entry scanned per cycle: insert writes the
//   tail; lookup scans up to the hit; a miss or victim scans all n entries; remove scans to
//   the hit, then pulls later entries down; touch scans to the hit, then ages all n entries.
// Reset clears only the entry count and control; entries are written before read.
// A result waits in the output register while the next beat is accepted; a stalled
// output holds the following result in the controller's response state.
module segment_table_lru_aging (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [stla_pkg::OP_W-1:0]    opcode,
    input  logic [stla_pkg::KEY_W-1:0]   process_id,
    input  logic [stla_pkg::KEY_W-1:0]   seg_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [stla_pkg::ST_W-1:0]    status,
    output logic [stla_pkg::KEY_W-1:0]   found_pid,
    output logic [stla_pkg::KEY_W-1:0]   found_seg,
    output logic [stla_pkg::SLOT_W-1:0]  found_slot
);

    stla_pkg::cmd_t cmd;
    stla_pkg::sts_t sts;

    stla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stla_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .process_id (process_id),
        .seg_number (seg_number),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_pid  (found_pid),
        .found_seg  (found_seg),
        .found_slot (found_slot)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_table_lru_aging: table predictor, scoreboard, drivers.
module testbench;

    typedef struct packed {
        logic [stla_pkg::ST_W-1:0]   status;
        logic [stla_pkg::KEY_W-1:0]  pid;
        logic [stla_pkg::KEY_W-1:0]  seg;
        logic [stla_pkg::SLOT_W-1:0] slot;
    } answer_t;

    typedef enum int {TR_GROW, TR_SHRINK, TR_CHURN} traffic_t;

    localparam logic [stla_pkg::OP_W-1:0]     OP_SPARE_5   = 3'd5;
    localparam logic [stla_pkg::OP_W-1:0]     OP_SPARE_6   = 3'd6;
    localparam logic [stla_pkg::OP_W-1:0]     OP_SPARE_7   = 3'd7;
    localparam logic [stla_pkg::AGE_BITS-1:0] AGE_CEIL     = '1;
    localparam int                            AGE_TOUCHES  = 12;
    localparam int                            RANDOM_ITEMS = 2000;
    localparam int                            MAX_PRINTS   = 30;

    class seg_table_scoreboard;
        logic [stla_pkg::KEY_W-1:0]    res_pid [stla_pkg::ENTRIES];
        logic [stla_pkg::KEY_W-1:0]    res_seg [stla_pkg::ENTRIES];
        logic [stla_pkg::AGE_BITS-1:0] res_age [stla_pkg::ENTRIES];
        int                            count;
        answer_t                       expected_answers [$];
        int                            errors;
        int                            checked;
        int                            op_seen [8];
        int                            status_seen [4];

        function int find_first(logic [stla_pkg::KEY_W-1:0] p, logic [stla_pkg::KEY_W-1:0] s);
            for (int i = 0; i < count; i++)
            begin
                if (res_pid[i] == p && res_seg[i] == s)
                    return i;
            end
            return -1;
        endfunction

        function answer_t hit_answer(int pos);
            answer_t a;
            a.status = stla_pkg::ST_OK;
            a.pid    = res_pid[pos];
            a.seg    = res_seg[pos];
            a.slot   = pos[stla_pkg::SLOT_W-1:0];
            return a;
        endfunction

        // Advances the table by one accepted beat and queues the answer it must produce.
        function void note_request(logic [stla_pkg::OP_W-1:0] op,
                                   logic [stla_pkg::KEY_W-1:0] p,
                                   logic [stla_pkg::KEY_W-1:0] s);
            answer_t a;
            int      pos;
            int      best;
            a = '{stla_pkg::ST_OK, '0, '0, '0};
            case (op)
                stla_pkg::OP_LOOKUP:
                begin
                    pos = find_first(p, s);
                    if (pos < 0)
                        a.status = stla_pkg::ST_NOT_FOUND;
                    else
                        a = hit_answer(pos);
                end
                stla_pkg::OP_INSERT:
                begin
                    if (count >= stla_pkg::ENTRIES)
                        a.status = stla_pkg::ST_FULL;
                    else
                    begin
                        res_pid[count] = p;
                        res_seg[count] = s;
                        res_age[count] = '0;
                        a = hit_answer(count);
                        count++;
                    end
                end
                stla_pkg::OP_TOUCH:
                begin
                    pos = find_first(p, s);
                    if (pos < 0)
                        a.status = stla_pkg::ST_NOT_FOUND;
                    else
                    begin
                        for (int i = 0; i < count; i++)
                        begin
                            if (res_age[i] != AGE_CEIL)
                                res_age[i] = res_age[i] + 1'b1;
                        end
                        res_age[pos] = '0;
                        a = hit_answer(pos);
                    end
                end
                stla_pkg::OP_VICTIM:
                begin
                    if (count == 0)
                        a.status = stla_pkg::ST_EMPTY;
                    else
                    begin
                        best = 0;
                        for (int i = 1; i < count; i++)
                        begin
                            if (res_age[i] > res_age[best])
                                best = i;
                        end
                        a = hit_answer(best);
                    end
                end
                stla_pkg::OP_REMOVE:
                begin
                    pos = find_first(p, s);
                    if (pos < 0)
                        a.status = stla_pkg::ST_NOT_FOUND;
                    else
                    begin
                        a = hit_answer(pos);
                        for (int i = pos; i + 1 < count; i++)
                        begin
                            res_pid[i] = res_pid[i + 1];
                            res_seg[i] = res_seg[i + 1];
                            res_age[i] = res_age[i + 1];
                        end
                        count--;
                    end
                end
                default:
                    a.status = stla_pkg::ST_OK;
            endcase
            op_seen[op]++;
            status_seen[a.status]++;
            expected_answers.push_back(a);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t: %s wrong at answer %0d: got %h, expected %h",
                         $time, what, checked, got, want);
        endtask

        task check_response(logic [stla_pkg::ST_W-1:0] st, logic [stla_pkg::KEY_W-1:0] p,
                            logic [stla_pkg::KEY_W-1:0] s, logic [stla_pkg::SLOT_W-1:0] sl);
            answer_t e;
            if (expected_answers.size() == 0)
            begin
                report_mismatch("unexpected beat, status", 16'(st), '0);
                return;
            end
            e = expected_answers.pop_front();
            checked++;
            if (st !== e.status)
                report_mismatch("status", 16'(st), 16'(e.status));
            if (p !== e.pid)
                report_mismatch("found_pid", 16'(p), 16'(e.pid));
            if (s !== e.seg)
                report_mismatch("found_seg", 16'(s), 16'(e.seg));
            if (sl !== e.slot)
                report_mismatch("found_slot", 16'(sl), 16'(e.slot));
        endtask

        task report_leftovers();
            answer_t e;
            while (expected_answers.size() != 0)
            begin
                e = expected_answers.pop_front();
                checked++;
                report_mismatch("missing beat, status", 'x, 16'(e.status));
            end
        endtask
    endclass

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_ready;
    logic [stla_pkg::OP_W-1:0]     opcode     = '0;
    logic [stla_pkg::KEY_W-1:0]    process_id = '0;
    logic [stla_pkg::KEY_W-1:0]    seg_number = '0;
    logic                          out_valid;
    logic                          out_ready  = 1'b0;
    logic [stla_pkg::ST_W-1:0]     status;
    logic [stla_pkg::KEY_W-1:0]    found_pid;
    logic [stla_pkg::KEY_W-1:0]    found_seg;
    logic [stla_pkg::SLOT_W-1:0]   found_slot;
    bit                            idle_on    = 1'b1;
    seg_table_scoreboard           sb         = new;

    segment_table_lru_aging u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .process_id (process_id),
        .seg_number (seg_number),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_pid  (found_pid),
        .found_seg  (found_seg),
        .found_slot (found_slot)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= idle_on ? ($urandom_range(0, 99) >= 16) : 1'b1;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(status, found_pid, found_seg, found_slot);
    end

    initial
    begin
        #200_000_000;
        $display("** segment_table_lru_aging: FAILED **");
        $finish;
    end

    // Presents one beat and returns on the edge that accepts it; valid stays up.
    task automatic send_beat(logic [stla_pkg::OP_W-1:0] op, logic [stla_pkg::KEY_W-1:0] p,
                             logic [stla_pkg::KEY_W-1:0] s);
        while (idle_on && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        process_id <= p;
        seg_number <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(op, p, s);
    endtask

    // Mostly resident keys so that hits dominate; a small pool makes duplicates.
    task automatic pick_key(output logic [stla_pkg::KEY_W-1:0] p,
                            output logic [stla_pkg::KEY_W-1:0] s);
        int r;
        int i;
        r = $urandom_range(0, 99);
        if (sb.count > 0 && r < 65)
        begin
            i = $urandom_range(0, sb.count - 1);
            p = sb.res_pid[i];
            s = sb.res_seg[i];
        end
        else if (r < 85)
        begin
            p = stla_pkg::KEY_W'($urandom_range(0, 3));
            s = stla_pkg::KEY_W'($urandom_range(0, 3));
        end
        else
        begin
            p = stla_pkg::KEY_W'($urandom);
            s = stla_pkg::KEY_W'($urandom);
        end
    endtask

    task automatic pick_op(traffic_t mode, output logic [stla_pkg::OP_W-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = stla_pkg::OP_W'(OP_SPARE_5 + $urandom_range(0, 2));
        else
        begin
            r = $urandom_range(0, 99);
            case (mode)
                TR_GROW:
                    op = r < 70 ? stla_pkg::OP_INSERT : r < 78 ? stla_pkg::OP_LOOKUP :
                         r < 86 ? stla_pkg::OP_TOUCH : r < 93 ? stla_pkg::OP_VICTIM :
                         stla_pkg::OP_REMOVE;
                TR_SHRINK:
                    op = r < 15 ? stla_pkg::OP_INSERT : r < 55 ? stla_pkg::OP_REMOVE :
                         r < 70 ? stla_pkg::OP_LOOKUP : r < 85 ? stla_pkg::OP_TOUCH :
                         stla_pkg::OP_VICTIM;
                default:
                    op = r < 20 ? stla_pkg::OP_INSERT : r < 40 ? stla_pkg::OP_REMOVE :
                         r < 60 ? stla_pkg::OP_LOOKUP : r < 85 ? stla_pkg::OP_TOUCH :
                         stla_pkg::OP_VICTIM;
            endcase
        end
    endtask

    initial
    begin
        logic [stla_pkg::KEY_W-1:0] p;
        logic [stla_pkg::KEY_W-1:0] s;
        logic [stla_pkg::OP_W-1:0]  op;
        traffic_t                   mode;
        int                         run_len;
        int                         sent;
        int                         i;
        int                         w;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, absent keys, spare opcodes
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_LOOKUP, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_TOUCH, 8'hff, 8'hff);
        send_beat(stla_pkg::OP_REMOVE, 8'h00, 8'h00);
        send_beat(OP_SPARE_5, 8'hff, 8'h00);
        send_beat(OP_SPARE_6, 8'h00, 8'hff);
        send_beat(OP_SPARE_7, 8'hff, 8'hff);
        // duplicates act on the first match
        send_beat(stla_pkg::OP_INSERT, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_INSERT, 8'hff, 8'hff);
        send_beat(stla_pkg::OP_INSERT, 8'ha5, 8'h5a);
        send_beat(stla_pkg::OP_INSERT, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_LOOKUP, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_TOUCH, 8'hff, 8'hff);
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_TOUCH, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_REMOVE, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_LOOKUP, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_REMOVE, 8'hff, 8'h00);
        send_beat(stla_pkg::OP_LOOKUP, 8'h00, 8'hff);
        send_beat(OP_SPARE_5, 8'h00, 8'h00);

        // fill to capacity, one rejected insert, then drain from random slots
        while (sb.count < stla_pkg::ENTRIES)
            send_beat(stla_pkg::OP_INSERT, stla_pkg::KEY_W'($urandom),
                      stla_pkg::KEY_W'($urandom));
        send_beat(stla_pkg::OP_INSERT, 8'hff, 8'h00);
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);
        while (sb.count > 0)
        begin
            i = $urandom_range(0, sb.count - 1);
            send_beat(stla_pkg::OP_REMOVE, sb.res_pid[i], sb.res_seg[i]);
        end
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);

        // the untouched entry grows oldest; touching it hands the victim back to slot 0
        send_beat(stla_pkg::OP_INSERT, 8'h11, 8'h22);
        send_beat(stla_pkg::OP_INSERT, 8'h33, 8'h44);
        repeat (AGE_TOUCHES) send_beat(stla_pkg::OP_TOUCH, 8'h11, 8'h22);
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);
        send_beat(stla_pkg::OP_TOUCH, 8'h33, 8'h44);
        send_beat(stla_pkg::OP_VICTIM, 8'h00, 8'h00);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode    = traffic_t'($urandom_range(0, 2));
            run_len = $urandom_range(20, 80);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++)
            begin
                idle_on = !(sent >= 900 && sent < 1200);
                pick_op(mode, op);
                pick_key(p, s);
                send_beat(op, p, s);
                sent++;
            end
        end
        in_valid <= 1'b0;
        idle_on = 1'b1;

        w = 0;
        while (sb.expected_answers.size() != 0 && w < 200000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (100) @(posedge clk);
        sb.report_leftovers();

        $display("Beats sent: %0d lookup, %0d insert, %0d touch, %0d victim, %0d remove, %0d spare",
                 sb.op_seen[stla_pkg::OP_LOOKUP], sb.op_seen[stla_pkg::OP_INSERT],
                 sb.op_seen[stla_pkg::OP_TOUCH], sb.op_seen[stla_pkg::OP_VICTIM],
                 sb.op_seen[stla_pkg::OP_REMOVE],
                 sb.op_seen[OP_SPARE_5] + sb.op_seen[OP_SPARE_6] + sb.op_seen[OP_SPARE_7]);
        $display("Answers checked: %0d (%0d not found, %0d full, %0d empty), %0d mismatches",
                 sb.checked, sb.status_seen[stla_pkg::ST_NOT_FOUND],
                 sb.status_seen[stla_pkg::ST_FULL], sb.status_seen[stla_pkg::ST_EMPTY],
                 sb.errors);
        if (sb.errors == 0)
            $display("** segment_table_lru_aging: PASSED **");
        else
            $display("** segment_table_lru_aging: FAILED **");
        $finish;
    end

endmodule

### segment_table_lru_aging.f
design/stla_pkg.sv
design/stla_dp.sv
design/stla_ctrl.sv
design/segment_table_lru_aging.sv
sim/testbench.sv
